// ===== src/marker_length_type_deframer_top_macros.svh =====
// Assertion macros for the marker/length/type deframer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MARKER_LENGTH_TYPE_DEFRAMER_TOP_MACROS_SVH
`define MARKER_LENGTH_TYPE_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define MLTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mltd_pkg.sv =====
// Shared types and constants of the marker/length/type deframer.
// No dependencies.
package mltd_pkg;

  localparam int MARKER_LEN = 16;
  localparam int HP_W = (MARKER_LEN > 1) ? $clog2(MARKER_LEN) : 1;
  localparam logic [HP_W-1:0] HP_LAST = HP_W'(MARKER_LEN - 1);
  localparam logic [16:0] TOTAL_BASE = 17'(MARKER_LEN + 2);

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;

  typedef enum logic [1:0] {
    ERR_MARKER = 2'd0,
    ERR_SHORT  = 2'd1,
    ERR_LONG   = 2'd2
  } err_code_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       is_error;
    logic [1:0] error_code;
  } res_t;

  typedef struct packed {
    logic wr;
    logic failed;
  } front_stat_t;

endpackage

// ===== src/mltd_front.sv =====
// Front end of the deframer: header parsing, length checks, result classification.
// Depends on mltd_pkg.
module mltd_front
  import mltd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_acc,
  input  logic [7:0]  in_data,
  input  logic [7:0]  marker_byte,
  input  logic [16:0] max_frame_bytes,
  output res_t        res,
  output front_stat_t stat
);

  typedef enum logic [2:0] {
    PH_MARKER  = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [HP_W-1:0] hp_r, hp_nxt;
  logic [7:0]      len_hi_r, len_hi_nxt;
  logic [15:0]     left_r, left_nxt;
  logic            failed_r, failed_nxt;
  logic            wr;
  logic [15:0]     body;
  logic [16:0]     total;
  logic [15:0]     left_dec;

  assign body     = {len_hi_r, in_data};
  assign total    = TOTAL_BASE + {1'b0, body};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    hp_nxt     = hp_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    failed_nxt = failed_r;
    wr         = 1'b0;
    res        = '0;
    if (in_acc && !failed_r) begin
      case (phase_r)
        PH_MARKER: begin
          if (in_data != marker_byte) begin
            wr             = 1'b1;
            res.is_error   = 1'b1;
            res.error_code = ERR_MARKER;
            failed_nxt     = 1'b1;
          end else if (hp_r == HP_LAST) begin
            hp_nxt    = '0;
            phase_nxt = PH_LEN_HI;
          end else begin
            hp_nxt = hp_r + 1'b1;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = in_data;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (body <= 16'd1) begin
            wr             = 1'b1;
            res.is_error   = 1'b1;
            res.error_code = ERR_SHORT;
            failed_nxt     = 1'b1;
          end else if (total > max_frame_bytes) begin
            wr             = 1'b1;
            res.is_error   = 1'b1;
            res.error_code = ERR_LONG;
            failed_nxt     = 1'b1;
          end else begin
            left_nxt  = body - 16'd1;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          phase_nxt = PH_PAYLOAD;
        end
        default: begin
          left_nxt          = left_dec;
          wr                = 1'b1;
          res.payload_byte  = in_data;
          res.last_of_frame = (left_dec == 16'd0);
          if (left_dec == 16'd0) begin
            phase_nxt = PH_MARKER;
            hp_nxt    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MARKER;
      hp_r     <= '0;
      len_hi_r <= '0;
      left_r   <= '0;
      failed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hp_r     <= hp_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      failed_r <= failed_nxt;
    end
  end

  assign stat.wr     = wr;
  assign stat.failed = failed_r;

endmodule

// ===== src/mltd_queue.sv =====
// Result queue between the front end and the output channel.
// Depends on mltd_pkg.
module mltd_queue
  import mltd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  res_t wr_res,
  input  logic rd,
  output res_t head,
  output logic empty,
  output logic full
);

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_wr, do_rd;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCW'(QDEPTH));
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/marker_length_type_deframer_top.sv =====
// Top level of the marker/length/type deframer: config registers, front end, result queue.
// Depends on mltd_pkg, mltd_front, mltd_queue and the assertion macro header.
//
//   channel  | handshake            | payload
//   input    | push / full          | in_data_byte
//   result   | empty / pop          | out_payload_byte, out_last_of_frame,
//            |                      | out_is_error, out_error_code
//   config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle in; a result is queued in the cycle its byte is taken.
// A result can be popped the cycle after its byte is pushed (4-entry queue).
// full rises only when four results wait; input then stalls until a pop.
// Synchronous active-low reset clears parser state and the queue, and sets the config registers to their defaults.
`include "marker_length_type_deframer_top_macros.svh"
module marker_length_type_deframer_top
  import mltd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_data_byte,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_payload_byte,
  output logic               out_last_of_frame,
  output logic               out_is_error,
  output logic [1:0]         out_error_code,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]  marker_r;
  logic [16:0] max_r;
  logic        cfg_wr;
  logic        in_acc;
  res_t        fres;
  res_t        head;
  front_stat_t fstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {15'd0, max_r} : {24'd0, marker_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= 8'hFF;
      max_r    <= 17'd65553;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        max_r <= pwdata[16:0];
      end else begin
        marker_r <= pwdata[7:0];
      end
    end
  end

  assign in_acc = push && !full;

  mltd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_acc          (in_acc),
    .in_data         (in_data_byte),
    .marker_byte     (marker_r),
    .max_frame_bytes (max_r),
    .res             (fres),
    .stat            (fstat)
  );

  mltd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (fstat.wr),
    .wr_res (fres),
    .rd     (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  assign out_payload_byte  = head.payload_byte;
  assign out_last_of_frame = head.last_of_frame;
  assign out_is_error      = head.is_error;
  assign out_error_code    = head.error_code;

  `MLTD_ASSERT_NOW(a_full_not_empty, full, !empty, "queue full while empty")
  `MLTD_ASSERT_NOW(a_silent_after_fail, fstat.failed, !fstat.wr, "result after error")
  `MLTD_ASSERT_NOW(a_last_not_err, !empty, !(out_last_of_frame && out_is_error), "last on error")
  `MLTD_ASSERT_NXT(a_pop_frees, pop && !empty && !fstat.wr, !full, "pop did not free space")

endmodule
